// ----- hw/rtl/dual_stepper_pulse_generator_defines.svh -----
// Assertion macros shared by the stepper pulse generator RTL.
`ifndef DUAL_STEPPER_PULSE_GENERATOR_DEFINES_SVH
`define DUAL_STEPPER_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsp check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define DSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsp check failed: next-cycle implication");

`endif

// ----- hw/rtl/dsp_pkg.sv -----
// Shared widths, command codes, controller states and interface structs.
package dsp_pkg;

  localparam int COUNT_WIDTH  = 32;
  localparam int PERIOD_WIDTH = 16;
  localparam int CFG_WIDTH    = 16;
  localparam int SEG_WIDTH    = 32;
  localparam int DUTY_WIDTH   = 7;
  localparam int CMD_WIDTH    = 4;
  localparam int IDX_WIDTH    = 2;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 8;

  typedef logic [PERIOD_WIDTH-1:0] period_t;
  typedef logic [DUTY_WIDTH-1:0]   duty_t;
  typedef logic [SEG_WIDTH-1:0]    seg_t;
  typedef logic [COUNT_WIDTH-1:0]  count_t;
  typedef logic [CFG_WIDTH-1:0]    cfg_t;

  // Command codes carried in s_tuser
  localparam logic [CMD_WIDTH-1:0] CMD_TICK       = 4'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_FORWARD    = 4'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_BACK       = 4'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_TURN_LEFT  = 4'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_TURN_RIGHT = 4'd4;
  localparam logic [CMD_WIDTH-1:0] CMD_STOP       = 4'd5;
  localparam logic [CMD_WIDTH-1:0] CMD_CORRECT    = 4'd6;
  localparam logic [CMD_WIDTH-1:0] CMD_GO_DIST    = 4'd7;
  localparam logic [CMD_WIDTH-1:0] CMD_SET_DUTY   = 4'd8;

  // Configuration register indexes
  localparam logic [IDX_WIDTH-1:0] REG_LEFT_BASE  = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_RIGHT_BASE = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_CPU        = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ISSUE0,
    ST_ISSUE1,
    ST_WAIT,
    ST_CHECK,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // latch the input transaction
    logic exec;        // apply the latched command
    logic issue;       // push one side into the length pipeline
    logic issue_side;  // 0 left, 1 right
    logic check;       // distance target check
    logic emit;        // load the output register
  } dsp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_len;    // latched command needs segment lengths
    logic len_busy;    // length pipeline holds work
    logic out_free;    // output register can take a result
  } dsp_stat_t;

endpackage

// ----- hw/rtl/dsp_len_unit.sv -----
// Five-stage pipeline that turns period and duty into high/low segment lengths.
module dsp_len_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             side,
  input  dsp_pkg::period_t pu,
  input  dsp_pkg::duty_t   duty,
  input  dsp_pkg::cfg_t    cpu,
  output logic             res_valid,
  output logic             res_side,
  output dsp_pkg::seg_t    res_high,
  output dsp_pkg::seg_t    res_low,
  output logic             busy
);

  localparam int PROD_W = dsp_pkg::PERIOD_WIDTH + dsp_pkg::CFG_WIDTH;
  localparam int QW     = 26;
  // floor(2^38 / 100): quotient estimate is exact or one low
  localparam logic [31:0] RECIP       = 32'hA3D7_0A3D;
  localparam int          RECIP_SHIFT = 38;
  localparam logic [7:0]  PCT         = 8'd100;
  // floor(x / 100) == (x * 5243) >> 19 for x up to 9801
  localparam logic [12:0] SMALL_RECIP = 13'd5243;
  localparam int          SMALL_SHIFT = 19;

  // stage 1: full period in counts
  logic             v1, s1;
  dsp_pkg::duty_t   d1;
  dsp_pkg::seg_t    t1;
  // stage 2: reciprocal product
  logic             v2, s2;
  dsp_pkg::duty_t   d2;
  dsp_pkg::seg_t    t2;
  logic [63:0]      qm2;
  // stage 3: quotient estimate and remainder
  logic             v3, s3;
  dsp_pkg::duty_t   d3;
  dsp_pkg::seg_t    t3;
  logic [QW-1:0]    q3;
  logic [7:0]       r3;
  // stage 4: split products
  logic             v4, s4;
  dsp_pkg::seg_t    t4;
  dsp_pkg::seg_t    qd4;
  logic [13:0]      rd4;

  dsp_pkg::cfg_t    cpu_eff;
  logic [PROD_W-1:0] prod;
  dsp_pkg::seg_t    t_sat;
  logic [QW-1:0]    q_est;
  logic [QW-1:0]    q_fix;
  logic [6:0]       r_fix;
  logic [26:0]      frac_full;
  dsp_pkg::seg_t    h_raw;
  dsp_pkg::seg_t    h_clamp;

  // zero ticks per unit counts as one; saturate to the segment width, floor of two
  always_comb begin
    cpu_eff = (cpu == '0) ? dsp_pkg::cfg_t'(1) : cpu;
    prod    = PROD_W'(pu) * PROD_W'(cpu_eff);
    if (64'(prod) > 64'h0000_0000_FFFF_FFFF) begin
      t_sat = '1;
    end else if (64'(prod) < 64'd2) begin
      t_sat = dsp_pkg::seg_t'(2);
    end else begin
      t_sat = dsp_pkg::SEG_WIDTH'(prod);
    end
  end

  assign q_est = qm2[RECIP_SHIFT +: QW];

  // one compare and subtract fixes the quotient estimate
  always_comb begin
    if (r3 >= PCT) begin
      q_fix = q3 + QW'(1);
      r_fix = 7'(r3 - PCT);
    end else begin
      q_fix = q3;
      r_fix = r3[6:0];
    end
  end

  // high = q*d + floor(r*d/100), held inside [1, period-1]
  always_comb begin
    frac_full = 27'(rd4) * 27'(SMALL_RECIP);
    h_raw     = qd4 + dsp_pkg::seg_t'(frac_full >> SMALL_SHIFT);
    if (h_raw == '0) begin
      h_clamp = dsp_pkg::seg_t'(1);
    end else if (h_raw >= t4) begin
      h_clamp = t4 - dsp_pkg::seg_t'(1);
    end else begin
      h_clamp = h_raw;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= start;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      res_valid <= v4;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1  <= side;
    d1  <= duty;
    t1  <= t_sat;

    s2  <= s1;
    d2  <= d1;
    t2  <= t1;
    qm2 <= 64'(t1) * 64'(RECIP);

    s3  <= s2;
    d3  <= d2;
    t3  <= t2;
    q3  <= q_est;
    r3  <= 8'(t2 - 32'(32'(q_est) * 32'(PCT)));

    s4  <= s3;
    t4  <= t3;
    qd4 <= 32'(32'(q_fix) * 32'(d3));
    rd4 <= 14'(r_fix) * 14'(d3);

    res_side <= s4;
    res_high <= h_clamp;
    res_low  <= t4 - h_clamp;
  end

  assign busy = v1 | v2 | v3 | v4 | res_valid;

endmodule

// ----- hw/rtl/dsp_datapath.sv -----
// Motion state, configuration registers, command execution and output register.
module dsp_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [dsp_pkg::IDX_WIDTH-1:0]   wr_index,
  input  dsp_pkg::cfg_t                   wr_data,
  input  logic [dsp_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [dsp_pkg::CMD_WIDTH-1:0]   s_tuser,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [dsp_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  dsp_pkg::dsp_cmd_t               cmd,
  output dsp_pkg::dsp_stat_t              stat
);

  localparam logic [1:0] DIR_FORWARD    = 2'b10;
  localparam logic [1:0] DIR_BACK       = 2'b01;
  localparam logic [1:0] DIR_TURN_LEFT  = 2'b11;
  localparam logic [1:0] DIR_TURN_RIGHT = 2'b00;
  localparam dsp_pkg::duty_t  DUTY_RUN    = 7'd50;
  localparam dsp_pkg::duty_t  DUTY_TURN   = 7'd30;
  localparam dsp_pkg::duty_t  DUTY_MIN    = 7'd1;
  localparam dsp_pkg::duty_t  DUTY_MAX    = 7'd99;
  localparam dsp_pkg::period_t TURN_PERIOD = dsp_pkg::period_t'(90);
  localparam dsp_pkg::period_t RESET_PERIOD = dsp_pkg::period_t'(2);
  localparam longint PERIOD_MAX = (64'd1 << dsp_pkg::PERIOD_WIDTH) - 64'd1;
  localparam int SUM_W = dsp_pkg::COUNT_WIDTH + 1;

  function automatic dsp_pkg::period_t sat_period(input logic signed [17:0] v);
    if (v < 18'sd2) begin
      return dsp_pkg::period_t'(2);
    end else if (longint'(v) > PERIOD_MAX) begin
      return dsp_pkg::period_t'(PERIOD_MAX);
    end else begin
      return dsp_pkg::period_t'(v);
    end
  endfunction

  function automatic dsp_pkg::duty_t sat_duty(input logic [7:0] d);
    if (d < 8'(DUTY_MIN)) begin
      return DUTY_MIN;
    end else if (d > 8'(DUTY_MAX)) begin
      return DUTY_MAX;
    end else begin
      return dsp_pkg::duty_t'(d);
    end
  endfunction

  // configuration
  dsp_pkg::cfg_t base_l, base_r, cpu;

  // latched input transaction
  logic [dsp_pkg::CMD_WIDTH-1:0] cmd_q;
  logic signed [15:0]            corr_q;
  logic [7:0]                    lduty_q, rduty_q;
  logic [31:0]                   steps_q;

  // motion state
  dsp_pkg::period_t pu    [2];
  dsp_pkg::duty_t   duty  [2];
  dsp_pkg::seg_t    seg   [2];
  logic [1:0]       lvl;
  dsp_pkg::count_t  edges [2];
  logic [1:0]       dir;
  logic             run, turn, rev, dist_run;
  logic [31:0]      target;
  logic             done_q;

  // pending segment reloads from the length pipeline
  logic [1:0]       load_mask;
  logic [1:0]       sel_high;

  // length pipeline
  logic             res_valid, res_side;
  dsp_pkg::seg_t    res_high, res_low;
  logic             len_busy;

  logic signed [17:0] corr_x, base_l_x, base_r_x, corr_l, corr_r;
  logic [SUM_W-1:0]   edge_sum;
  logic               target_hit;
  logic               start_cmd;

  dsp_len_unit u_len (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.issue),
    .side      (cmd.issue_side),
    .pu        (pu[cmd.issue_side]),
    .duty      (duty[cmd.issue_side]),
    .cpu       (cpu),
    .res_valid (res_valid),
    .res_side  (res_side),
    .res_high  (res_high),
    .res_low   (res_low),
    .busy      (len_busy)
  );

  // steering correction sums
  always_comb begin
    corr_x   = 18'(corr_q);
    base_l_x = $signed({2'b00, base_l});
    base_r_x = $signed({2'b00, base_r});
    corr_l   = rev ? (base_l_x - corr_x) : (base_l_x + corr_x);
    corr_r   = rev ? (base_r_x + corr_x) : (base_r_x - corr_x);
  end

  // distance progress: (left + right edges) / 4 against the target
  always_comb begin
    edge_sum   = SUM_W'(edges[0]) + SUM_W'(edges[1]);
    target_hit = 33'(edge_sum >> 2) >= 33'(target);
  end

  // commands that start a motion always reload both segments
  always_comb begin
    case (cmd_q)
      dsp_pkg::CMD_FORWARD, dsp_pkg::CMD_BACK,
      dsp_pkg::CMD_TURN_LEFT, dsp_pkg::CMD_TURN_RIGHT: start_cmd = 1'b1;
      dsp_pkg::CMD_GO_DIST: start_cmd = (steps_q != '0);
      default: start_cmd = 1'b0;
    endcase
  end

  assign stat.need_len = start_cmd ||
                         ((cmd_q == dsp_pkg::CMD_TICK) && run &&
                          ((seg[0] <= dsp_pkg::seg_t'(1)) || (seg[1] <= dsp_pkg::seg_t'(1))));
  assign stat.len_busy = len_busy;
  assign stat.out_free = !m_tvalid || m_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_l <= dsp_pkg::cfg_t'(50);
      base_r <= dsp_pkg::cfg_t'(50);
      cpu    <= dsp_pkg::cfg_t'(1);
    end else if (wr_en) begin
      case (wr_index)
        dsp_pkg::REG_LEFT_BASE:  base_l <= wr_data;
        dsp_pkg::REG_RIGHT_BASE: base_r <= wr_data;
        dsp_pkg::REG_CPU:        cpu    <= wr_data;
        default: ;
      endcase
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_q   <= s_tuser;
      corr_q  <= s_tdata[15:0];
      lduty_q <= s_tdata[23:16];
      rduty_q <= s_tdata[31:24];
      steps_q <= s_tdata[63:32];
    end
  end

  // command execution, segment reloads and distance check
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        pu[s]    <= RESET_PERIOD;
        duty[s]  <= DUTY_RUN;
        seg[s]   <= '0;
        edges[s] <= '0;
      end
      lvl       <= '0;
      dir       <= '0;
      run       <= 1'b0;
      turn      <= 1'b0;
      rev       <= 1'b0;
      dist_run  <= 1'b0;
      target    <= '0;
      done_q    <= 1'b0;
      load_mask <= '0;
      sel_high  <= '0;
    end else begin
      if (cmd.exec) begin
        case (cmd_q)
          dsp_pkg::CMD_TICK: begin
            for (int s = 0; s < 2; s++) begin
              load_mask[s] <= run && (seg[s] <= dsp_pkg::seg_t'(1));
              if (run) begin
                if (seg[s] > dsp_pkg::seg_t'(1)) begin
                  seg[s] <= seg[s] - dsp_pkg::seg_t'(1);
                end else begin
                  lvl[s]      <= ~lvl[s];
                  edges[s]    <= edges[s] + dsp_pkg::count_t'(1);
                  sel_high[s] <= ~lvl[s];
                end
              end
            end
          end
          dsp_pkg::CMD_FORWARD, dsp_pkg::CMD_BACK: begin
            pu[0]     <= sat_period($signed({2'b00, base_l}));
            pu[1]     <= sat_period($signed({2'b00, base_r}));
            duty[0]   <= DUTY_RUN;
            duty[1]   <= DUTY_RUN;
            dir       <= (cmd_q == dsp_pkg::CMD_FORWARD) ? DIR_FORWARD : DIR_BACK;
            rev       <= (cmd_q == dsp_pkg::CMD_BACK);
            turn      <= 1'b0;
            if (cmd_q == dsp_pkg::CMD_FORWARD) begin
              dist_run <= 1'b0;
            end
            lvl       <= '0;
            edges[0]  <= '0;
            edges[1]  <= '0;
            run       <= 1'b1;
            load_mask <= 2'b11;
            sel_high  <= 2'b00;
          end
          dsp_pkg::CMD_TURN_LEFT, dsp_pkg::CMD_TURN_RIGHT: begin
            pu[0]     <= TURN_PERIOD;
            pu[1]     <= TURN_PERIOD;
            duty[0]   <= DUTY_TURN;
            duty[1]   <= DUTY_TURN;
            dir       <= (cmd_q == dsp_pkg::CMD_TURN_LEFT) ? DIR_TURN_LEFT : DIR_TURN_RIGHT;
            turn      <= 1'b1;
            rev       <= 1'b0;
            lvl       <= '0;
            edges[0]  <= '0;
            edges[1]  <= '0;
            run       <= 1'b1;
            load_mask <= 2'b11;
            sel_high  <= 2'b00;
          end
          dsp_pkg::CMD_STOP: begin
            run      <= 1'b0;
            dist_run <= 1'b0;
            lvl      <= '0;
          end
          dsp_pkg::CMD_CORRECT: begin
            if (!turn) begin
              pu[0] <= sat_period(corr_l);
              pu[1] <= sat_period(corr_r);
            end
          end
          dsp_pkg::CMD_GO_DIST: begin
            if (steps_q == '0) begin
              target   <= '0;
              run      <= 1'b0;
              dist_run <= 1'b0;
              lvl      <= '0;
            end else begin
              pu[0]     <= sat_period($signed({2'b00, base_l}));
              pu[1]     <= sat_period($signed({2'b00, base_r}));
              duty[0]   <= DUTY_RUN;
              duty[1]   <= DUTY_RUN;
              dir       <= DIR_FORWARD;
              rev       <= 1'b0;
              turn      <= 1'b0;
              lvl       <= '0;
              edges[0]  <= '0;
              edges[1]  <= '0;
              run       <= 1'b1;
              dist_run  <= 1'b1;
              target    <= steps_q;
              load_mask <= 2'b11;
              sel_high  <= 2'b00;
            end
          end
          dsp_pkg::CMD_SET_DUTY: begin
            duty[0] <= sat_duty(lduty_q);
            duty[1] <= sat_duty(rduty_q);
          end
          default: ;
        endcase
      end

      // segment reload from the length pipeline
      if (res_valid && load_mask[res_side]) begin
        seg[res_side] <= sel_high[res_side] ? res_high : res_low;
      end

      // distance target reached: halt and flag it for this result
      if (cmd.check) begin
        done_q <= dist_run && target_hit;
        if (dist_run && target_hit) begin
          run      <= 1'b0;
          dist_run <= 1'b0;
          lvl      <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {1'b0, done_q, dist_run, run, dir[1], dir[0], lvl[1], lvl[0]};
    end
  end

endmodule

// ----- hw/rtl/dsp_ctrl.sv -----
// Sequencer: accept, execute, length fetch, distance check, result hand-off.
module dsp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  dsp_pkg::dsp_stat_t stat,
  output dsp_pkg::dsp_cmd_t  cmd
);

  dsp_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dsp_pkg::ST_IDLE:   if (s_tvalid) state_next = dsp_pkg::ST_EXEC;
      dsp_pkg::ST_EXEC:   state_next = stat.need_len ? dsp_pkg::ST_ISSUE0 : dsp_pkg::ST_CHECK;
      dsp_pkg::ST_ISSUE0: state_next = dsp_pkg::ST_ISSUE1;
      dsp_pkg::ST_ISSUE1: state_next = dsp_pkg::ST_WAIT;
      dsp_pkg::ST_WAIT:   if (!stat.len_busy) state_next = dsp_pkg::ST_CHECK;
      dsp_pkg::ST_CHECK:  state_next = dsp_pkg::ST_EMIT;
      dsp_pkg::ST_EMIT:   if (stat.out_free) state_next = dsp_pkg::ST_IDLE;
      default:            state_next = dsp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready       = (state == dsp_pkg::ST_IDLE);
    cmd.take       = (state == dsp_pkg::ST_IDLE) && s_tvalid;
    cmd.exec       = (state == dsp_pkg::ST_EXEC);
    cmd.issue      = (state == dsp_pkg::ST_ISSUE0) || (state == dsp_pkg::ST_ISSUE1);
    cmd.issue_side = (state == dsp_pkg::ST_ISSUE1);
    cmd.check      = (state == dsp_pkg::ST_CHECK);
    cmd.emit       = (state == dsp_pkg::ST_EMIT) && stat.out_free;
  end

endmodule

// ----- hw/rtl/dual_stepper_pulse_generator.sv -----
// Top level of the two-channel STEP/DIR pulse generator.
//
// Each input transaction carries one command (tick, forward, back, turn left/right, stop,
// correct, go distance, set duty) and yields exactly one status result: both STEP
// levels, both DIR levels, running, distance busy and a one-result distance done flag.
// Only tick advances the segment counters. Items are handled one at a time: an item
// that reloads no segment passes execute, distance check and emit before the next can be
// taken; a start command, or a tick on which a segment expires, also issues the left and
// then the right side into the five-stage length pipeline that derives the high and low
// counts (period times duty over 100) and waits for it to drain. The result register lets
// the next item in while a result still waits on m_tready. Configuration writes take effect
// at once and belong in idle time only.
`include "dual_stepper_pulse_generator_defines.svh"

module dual_stepper_pulse_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [dsp_pkg::IDX_WIDTH-1:0]   wr_index,
  input  dsp_pkg::cfg_t                   wr_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [15:0] correction, [23:16] left_duty_arg, [31:24] right_duty_arg,
  // [63:32] distance_steps
  input  logic [dsp_pkg::IN_DATA_W-1:0]   s_tdata,
  // [3:0] cmd
  input  logic [dsp_pkg::CMD_WIDTH-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] left_step, [1] right_step, [2] left direction, [3] right direction,
  // [4] running, [5] distance_busy, [6] distance_done, [7] zero
  output logic [dsp_pkg::OUT_DATA_W-1:0]  m_tdata
);

  dsp_pkg::dsp_cmd_t  cmd;
  dsp_pkg::dsp_stat_t stat;

  dsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dsp_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

  // an accepted item blocks the input until it has been worked off
  `DSP_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  // no length work left over once the block takes a new item
  `DSP_ASSERT_NOW(a_len_idle, clk, rst, s_tready, !stat.len_busy)
  // a distance run always has the pulses running
  `DSP_ASSERT_NOW(a_dist_runs, clk, rst, m_tvalid && m_tdata[5], m_tdata[4])
  // stopped outputs hold both STEP pins low
  `DSP_ASSERT_NOW(a_stop_low, clk, rst, m_tvalid && !m_tdata[4], m_tdata[1:0] == 2'b00)

endmodule
